[rtl/core/tun_pkg.sv]
// shared widths and sideband types for the triangle unit normal pipeline
// no dependencies; compiled first
package tun_pkg;

    // normalized cross magnitude width, square and sum widths
    localparam int M_BITS = 31;
    localparam int SQ_W   = 2 * M_BITS;
    localparam int SUM_W  = 64;
    // integer square root of the sum
    localparam int ROOT_W = SUM_W / 2;
    // width of each normal component port
    localparam int OUT_W  = 16;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } tun_flags_t;

    typedef struct packed {
        logic [2:0][M_BITS-1:0] m;
        tun_flags_t             flags;
    } tun_side_t;

endpackage

[rtl/core/triangle_unit_normal_top.sv]
// unit face normal of one triangle per transaction, fully pipelined
// a transaction passes the edge, product, cross, normalize, square and sum
// registers, the square root and divider stages and the output register
// throughput: one transaction per cycle, busy stays low; the depth is set
// by the 32-stage square root and the one-bit-per-stage divider
// reset clears only the valid bits; results in flight are dropped
module triangle_unit_normal_top #(
    parameter int COORD_BITS       = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [COORD_BITS-1:0]       v0_x,
    input  logic signed [COORD_BITS-1:0]       v0_y,
    input  logic signed [COORD_BITS-1:0]       v0_z,
    input  logic signed [COORD_BITS-1:0]       v1_x,
    input  logic signed [COORD_BITS-1:0]       v1_y,
    input  logic signed [COORD_BITS-1:0]       v1_z,
    input  logic signed [COORD_BITS-1:0]       v2_x,
    input  logic signed [COORD_BITS-1:0]       v2_y,
    input  logic signed [COORD_BITS-1:0]       v2_z,
    output logic                               done,
    output logic signed [tun_pkg::OUT_W-1:0]   normal_x,
    output logic signed [tun_pkg::OUT_W-1:0]   normal_y,
    output logic signed [tun_pkg::OUT_W-1:0]   normal_z,
    output logic                               degenerate
);
    import tun_pkg::*;

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int CW  = PW + 1;
    localparam int MW  = PW;
    localparam int EW  = (MW > M_BITS) ? MW : M_BITS;
    localparam int QW  = NORMAL_FRAC_BITS + 1;
    localparam int XW  = (QW > OUT_W) ? QW : OUT_W;

    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                         s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic signed [DW-1:0]         u_reg [3];
    logic signed [DW-1:0]         v_reg [3];
    logic signed [PW-1:0]         p_reg [6];
    logic [2:0][MW-1:0]           mag_reg;
    logic [2:0]                   neg_reg;
    logic [2:0][MW-1:0]           mag_next;
    logic [2:0]                   neg_next;
    tun_side_t                    s4_side_reg, s5_side_reg, s6_side_reg;
    tun_side_t                    s4_side_next;
    logic [2:0][SQ_W-1:0]         sq_reg;
    logic [SUM_W-1:0]             sum_reg;
    logic                         sq_valid;
    logic [ROOT_W-1:0]            sq_root;
    tun_side_t                    sq_side;
    logic                         dv_valid;
    logic [2:0][QW-1:0]           dv_q;
    tun_flags_t                   dv_flags;
    logic                         done_reg;
    logic [2:0][OUT_W-1:0]        normal_reg;
    logic [2:0][OUT_W-1:0]        normal_next;
    logic                         degen_reg;

    // the pipeline never stalls
    assign busy = 1'b0;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            done_reg     <= dv_valid;
        end
    end

    // cross components as sign and magnitude
    always_comb
    begin
        logic signed [CW-1:0] c [3];
        c[0] = CW'(p_reg[0]) - CW'(p_reg[1]);
        c[1] = CW'(p_reg[2]) - CW'(p_reg[3]);
        c[2] = CW'(p_reg[4]) - CW'(p_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = c[i][CW-1];
            mag_next[i] = c[i][CW-1] ? MW'(-c[i]) : MW'(c[i]);
        end
    end

    // normalize so the largest magnitude fits M_BITS
    always_comb
    begin
        logic [MW-1:0] or_all;
        logic [EW-1:0] ext;
        int            k;
        or_all = mag_reg[0] | mag_reg[1] | mag_reg[2];
        k = 0;
        for (int j = M_BITS; j < MW; j++)
        begin
            if (or_all[j])
                k = j - M_BITS + 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            ext = EW'(mag_reg[i]);
            s4_side_next.m[i] = M_BITS'(ext >> k);
        end
        s4_side_next.flags.neg   = neg_reg;
        s4_side_next.flags.degen = (or_all == '0);
    end

    // arithmetic stages: edges, products, cross, normalize, squares, sum
    always_ff @(posedge clk)
    begin
        u_reg[0] <= DW'(v1_x) - DW'(v0_x);
        u_reg[1] <= DW'(v1_y) - DW'(v0_y);
        u_reg[2] <= DW'(v1_z) - DW'(v0_z);
        v_reg[0] <= DW'(v2_x) - DW'(v0_x);
        v_reg[1] <= DW'(v2_y) - DW'(v0_y);
        v_reg[2] <= DW'(v2_z) - DW'(v0_z);

        p_reg[0] <= PW'(u_reg[1]) * PW'(v_reg[2]);
        p_reg[1] <= PW'(u_reg[2]) * PW'(v_reg[1]);
        p_reg[2] <= PW'(u_reg[2]) * PW'(v_reg[0]);
        p_reg[3] <= PW'(u_reg[0]) * PW'(v_reg[2]);
        p_reg[4] <= PW'(u_reg[0]) * PW'(v_reg[1]);
        p_reg[5] <= PW'(u_reg[1]) * PW'(v_reg[0]);

        mag_reg <= mag_next;
        neg_reg <= neg_next;

        s4_side_reg <= s4_side_next;

        for (int i = 0; i < 3; i++)
            sq_reg[i] <= SQ_W'(s4_side_reg.m[i]) * SQ_W'(s4_side_reg.m[i]);
        s5_side_reg <= s4_side_reg;

        sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        s6_side_reg <= s5_side_reg;
    end

    // square root of the sum of squares
    tun_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_n      (sum_reg),
        .in_side   (s6_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // scale each magnitude by the root
    tun_div #(
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_flags (dv_flags)
    );

    // apply sign, zero the degenerate case
    always_comb
    begin
        logic [XW-1:0] qe;
        logic [XW-1:0] sv;
        for (int i = 0; i < 3; i++)
        begin
            qe = XW'(dv_q[i]);
            sv = dv_flags.neg[i] ? -qe : qe;
            normal_next[i] = dv_flags.degen ? '0 : sv[OUT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        normal_reg <= normal_next;
        degen_reg  <= dv_flags.degen;
    end

    assign done       = done_reg;
    assign normal_x   = normal_reg[0];
    assign normal_y   = normal_reg[1];
    assign normal_z   = normal_reg[2];
    assign degenerate = degen_reg;

endmodule

[rtl/core/tun_isqrt.sv]
// pipelined integer square root, one root bit per stage, with sideband
// depends on tun_pkg
module tun_isqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [tun_pkg::SUM_W-1:0] in_n,
    input  tun_pkg::tun_side_t       in_side,
    output logic                     out_valid,
    output logic [tun_pkg::ROOT_W-1:0] out_root,
    output tun_pkg::tun_side_t       out_side
);
    import tun_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic                      valid_reg [ROOT_W];
    logic [REM_W-1:0]          rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]         root_reg  [ROOT_W];
    logic [SUM_W-1:0]          n_reg     [ROOT_W];
    tun_side_t                 side_reg  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  n_in;
        tun_side_t         side_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (s == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = in_n;
            assign side_in = in_side;
        end
        else begin : g_rest
            assign v_in    = valid_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign n_in    = n_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        // bring down two bits and try the next root bit
        always_comb
        begin
            rem_sh = {rem_in, n_in[SUM_W-1 -: 2]};
            trial  = (REM_W+2)'({root_in, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= v_in;
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= rem_next;
            root_reg[s] <= root_next;
            n_reg[s]    <= {n_in[SUM_W-3:0], 2'b00};
            side_reg[s] <= side_in;
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

[rtl/core/tun_div.sv]
// pipelined restoring divider, three lanes, one quotient bit per stage
// depends on tun_pkg
module tun_div #(
    parameter int QW = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tun_pkg::ROOT_W-1:0]  in_root,
    input  tun_pkg::tun_side_t          in_side,
    output logic                        out_valid,
    output logic [2:0][QW-1:0]          out_q,
    output tun_pkg::tun_flags_t         out_flags
);
    import tun_pkg::*;

    localparam int RW = ROOT_W + 1;

    logic                     valid_reg [QW];
    logic [2:0][ROOT_W-1:0]   rem_reg   [QW];
    logic [2:0][QW-1:0]       q_reg     [QW];
    logic [ROOT_W-1:0]        root_reg  [QW];
    tun_flags_t               flags_reg [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic                   v_in;
        logic [ROOT_W-1:0]      r_in;
        tun_flags_t             f_in;
        logic [2:0][RW-1:0]     a_in;
        logic [2:0][QW-1:0]     q_in;
        logic [2:0][ROOT_W-1:0] rem_next;
        logic [2:0][QW-1:0]     q_next;

        if (s == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_root;
            assign f_in = in_side.flags;
            assign q_in = '0;
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign a_in[i] = RW'(in_side.m[i]);
            end
        end
        else begin : g_rest
            assign v_in = valid_reg[s-1];
            assign r_in = root_reg[s-1];
            assign f_in = flags_reg[s-1];
            assign q_in = q_reg[s-1];
            for (genvar i = 0; i < 3; i++) begin : g_lane
                assign a_in[i] = {rem_reg[s-1][i], 1'b0};
            end
        end

        // compare and subtract per lane
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (a_in[i] >= {1'b0, r_in})
                begin
                    rem_next[i] = ROOT_W'(a_in[i] - {1'b0, r_in});
                    q_next[i]   = {q_in[i][QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = a_in[i][ROOT_W-1:0];
                    q_next[i]   = {q_in[i][QW-2:0], 1'b0};
                end
            end
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= v_in;
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            rem_reg[s]   <= rem_next;
            q_reg[s]     <= q_next;
            root_reg[s]  <= r_in;
            flags_reg[s] <= f_in;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_q     = q_reg[QW-1];
    assign out_flags = flags_reg[QW-1];

endmodule

[rtl/core/tun_checker.sv]
// port-level checks for the triangle unit normal top, attached by bind
// depends on tun_pkg and triangle_unit_normal_top
module tun_checker #(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic signed [tun_pkg::OUT_W-1:0] normal_x,
    input logic signed [tun_pkg::OUT_W-1:0] normal_y,
    input logic signed [tun_pkg::OUT_W-1:0] normal_z,
    input logic                             degenerate
);
    import tun_pkg::*;

    localparam int LAT = 6 + ROOT_W + NORMAL_FRAC_BITS + 1 + 1;

    // a result always traces back to a transaction a fixed latency earlier
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching transaction");

    // degenerate results carry a zero vector
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
        else $error("degenerate result with nonzero normal");

    // a proper triangle never yields an all-zero normal
    a_nondegen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !degenerate) |-> (normal_x != 0 || normal_y != 0 || normal_z != 0))
        else $error("zero normal without degenerate flag");

    // no backpressure toward the sender
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("busy raised");

endmodule

bind triangle_unit_normal_top tun_checker #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tun_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
);
